// ----- hw/rtl/pru_pkg.sv -----
// shared types and constants of the pixel replication upscaler
package pru_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;
	localparam int FACTOR_W   = 7;
	localparam int SWIDTH_W   = 11;

	localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH = 1'b1;

	localparam logic OP_SOURCE = 1'b0;
	localparam logic OP_REPLAY = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
		logic [1:0] pad_bytes;
		logic       row_end;
		logic       run_last;
		logic       phase_error;
	} out_item_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic load;
	} pru_cmd_t;

	typedef struct packed {
		logic last_copy;
		logic out_free;
	} pru_status_t;

endpackage

// ----- hw/rtl/pru_ctrl.sv -----
// controller of the upscaler: accepts one item, then sequences its copies
module pru_ctrl
	import pru_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  pru_status_t status,
	output pru_cmd_t    cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free && status.last_copy) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		cmd.accept = 1'b0;
		cmd.load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			ST_EMIT: begin
				cmd.load = status.out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

// ----- hw/rtl/pru_datapath.sv -----
// datapath of the upscaler: registers, line buffer, row state and output register
module pru_datapath
	import pru_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_FACTOR = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  pru_cmd_t              cmd,
	output pru_status_t           status
);

	localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int EW  = $clog2(MAX_WIDTH + 1);
	localparam int FW  = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
	localparam int EFW = $clog2(MAX_FACTOR + 1);

	logic [FACTOR_W-1:0] scale_factor_q;
	logic [SWIDTH_W-1:0] source_width_q;

	logic [CW-1:0] col_q;
	logic [FW-1:0] replays_q;
	logic          phase_q;

	logic [23:0] line_buf [MAX_WIDTH];
	logic [23:0] rd_q;
	logic [23:0] pix_q;

	logic           src_q;
	logic           err_q;
	logic           at_end_q;
	logic [1:0]     pad_q;
	logic [EFW-1:0] f_q;
	logic [FW-1:0]  cnt_q;

	logic           out_valid_q;
	out_item_t      out_q;

	logic [EFW-1:0] f_eff;
	logic [EW-1:0]  w_eff;
	logic [EW-1:0]  last_col;
	logic [EW-1:0]  col_ext;
	logic [EW-1:0]  col_eff;
	logic [CW-1:0]  addr;
	logic           at_end;
	logic           item_err;
	logic [1:0]     w2;
	logic [1:0]     f2;
	logic [1:0]     pad;
	logic [FW-1:0]  replays_dec;
	logic           copy_last;
	logic           out_free;
	logic [23:0]    pix_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_factor_q <= FACTOR_W'(1);
			source_width_q <= SWIDTH_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCALE_FACTOR: scale_factor_q <= cfg_data[FACTOR_W-1:0];
				REG_SOURCE_WIDTH: source_width_q <= cfg_data[SWIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp the registers to the supported ranges
	always_comb begin
		if (scale_factor_q == '0) begin
			f_eff = EFW'(1);
		end else if (32'(scale_factor_q) > 32'(MAX_FACTOR)) begin
			f_eff = EFW'(MAX_FACTOR);
		end else begin
			f_eff = EFW'(scale_factor_q);
		end
		if (source_width_q == '0) begin
			w_eff = EW'(1);
		end else if (32'(source_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = EW'(MAX_WIDTH);
		end else begin
			w_eff = EW'(source_width_q);
		end
	end

	assign last_col    = w_eff - EW'(1);
	assign col_ext     = EW'(col_q);
	assign at_end      = (col_ext >= last_col);
	assign col_eff     = at_end ? last_col : col_ext;
	assign addr        = CW'(col_eff);
	assign item_err    = (in_data.op != phase_q);
	assign replays_dec = replays_q - FW'(1);

	// -(3*w*f) mod 4 reduces to (w*f) mod 4
	assign w2  = 2'(w_eff);
	assign f2  = 2'(f_eff);
	assign pad = 2'(w2 * f2);

	// row and replay bookkeeping, updated when the item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			replays_q <= '0;
			phase_q   <= OP_SOURCE;
		end else if (cmd.accept && !item_err) begin
			if (at_end) begin
				col_q <= '0;
				if (in_data.op == OP_SOURCE) begin
					if (f_eff > EFW'(1)) begin
						phase_q   <= OP_REPLAY;
						replays_q <= FW'(f_eff - EFW'(1));
					end
				end else begin
					replays_q <= replays_dec;
					if (replays_dec == '0) begin
						phase_q <= OP_SOURCE;
					end
				end
			end else begin
				col_q <= CW'(col_eff + EW'(1));
			end
		end
	end

	// line buffer, read data registered
	always_ff @(posedge clk) begin
		if (cmd.accept && !item_err && in_data.op == OP_SOURCE) begin
			line_buf[addr] <= {in_data.red, in_data.green, in_data.blue};
		end
		if (cmd.accept) begin
			rd_q <= line_buf[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pix_q <= {in_data.red, in_data.green, in_data.blue};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q    <= 1'b1;
			err_q    <= 1'b0;
			at_end_q <= 1'b0;
			pad_q    <= '0;
			f_q      <= EFW'(1);
			cnt_q    <= '0;
		end else if (cmd.accept) begin
			src_q    <= (in_data.op == OP_SOURCE);
			err_q    <= item_err;
			at_end_q <= at_end;
			pad_q    <= at_end ? pad : 2'b00;
			f_q      <= f_eff;
			cnt_q    <= '0;
		end else if (cmd.load) begin
			cnt_q <= cnt_q + FW'(1);
		end
	end

	assign copy_last = err_q || ((EFW'(cnt_q) + EFW'(1)) == f_q);
	assign pix_sel   = src_q ? pix_q : rd_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (err_q) begin
				out_q.out_blue    <= 8'h00;
				out_q.out_green   <= 8'h00;
				out_q.out_red     <= 8'h00;
				out_q.pad_bytes   <= 2'b00;
				out_q.row_end     <= 1'b0;
				out_q.run_last    <= 1'b1;
				out_q.phase_error <= 1'b1;
			end else begin
				out_q.out_blue    <= pix_sel[7:0];
				out_q.out_green   <= pix_sel[15:8];
				out_q.out_red     <= pix_sel[23:16];
				out_q.pad_bytes   <= copy_last ? pad_q : 2'b00;
				out_q.row_end     <= copy_last && at_end_q;
				out_q.run_last    <= copy_last;
				out_q.phase_error <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign out_data         = out_q;
	assign status.last_copy = copy_last;
	assign status.out_free  = out_free;

	a_err_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.phase_error |-> out_q.run_last && !out_q.row_end)
		else $error("phase error result not a lone last item");

	a_row_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.row_end |-> out_q.run_last)
		else $error("row end on a copy that is not the last");

	a_pad_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.pad_bytes != 2'b00 |-> out_q.row_end)
		else $error("padding outside a row end");

	a_replays_owed: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == OP_REPLAY |-> replays_q != '0)
		else $error("replay phase with no rows owed");

	a_copy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> EFW'(cnt_q) < f_q)
		else $error("copy count ran past the factor");

endmodule

// ----- hw/rtl/pixel_replication_upscaler_unit.sv -----
// top level of the pixel replication upscaler
//
//  channel   direction  handshake             payload
//  in        input      in_valid / in_stall   in_data   (in_item_t)
//  out       output     out_valid / out_stall out_data  (out_item_t)
//  cfg       input      cfg_we                cfg_index, cfg_data
//
// an item is taken first, then its f copies leave at one per cycle while out_stall is low
// (f = clamped scale factor, 1 for a phase error), and no new item is taken meanwhile;
// the single output register, issuing one copy a cycle unless stalled, sets this rate.
// the next item is taken while the last copy still waits in the output register.
// reset clears the row state and handshakes at once; the line buffer is not cleared.
// out_stall holds the output register and pauses copy emission.
module pixel_replication_upscaler_unit
	import pru_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_FACTOR = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data
);

	pru_cmd_t    cmd;
	pru_status_t status;

	pru_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	pru_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_FACTOR (MAX_FACTOR)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cmd       (cmd),
		.status    (status)
	);

endmodule
